// ===== sv/autorange_led_bar_level_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the auto-ranging LED bar level block
// Concurrent checks that vanish when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef AUTORANGE_LED_BAR_LEVEL_MACROS_SVH
`define AUTORANGE_LED_BAR_LEVEL_MACROS_SVH

`ifndef SYNTH
// Property checked on every rising edge while out of reset.
`define ARLBL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be seen while out of reset.
`define ARLBL_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ARLBL_ASSERT(label, clk, rst_n, prop, msg)
`define ARLBL_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ===== sv/arlbl_pkg.sv =====
// ---------------------------------------------------------------------------
// Auto-ranging LED bar level package
// Shared widths, constants and types of the block.
// ---------------------------------------------------------------------------
`default_nettype none

package arlbl_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int READING_W = 8;
    localparam int LEVEL_W   = 3;
    localparam int PATTERN_W = 8;

    // Adding this with wrap turns a two's complement reading into offset binary.
    localparam logic [READING_W-1:0] READING_OFFSET = 8'h80;

    // One classified reading, handed from the front end to the divider.
    typedef struct packed {
        logic [READING_W-1:0] diff;     // reading minus lowest
        logic [READING_W-1:0] span;     // highest minus lowest, never zero
        logic [READING_W-1:0] lowest;
        logic [READING_W-1:0] highest;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ===== sv/arlbl_if.sv =====
// ---------------------------------------------------------------------------
// Auto-ranging LED bar level channels
// Valid/ready interfaces for samples, internal jobs and results.
// ---------------------------------------------------------------------------
`default_nettype none

interface arlbl_sample_if;
    import arlbl_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_word;

    modport source (output valid, output sample_word, input ready);
    modport sink   (input valid, input sample_word, output ready);
endinterface

interface arlbl_job_if;
    import arlbl_pkg::*;

    logic valid;
    logic ready;
    job_t job;

    modport source (output valid, output job, input ready);
    modport sink   (input valid, input job, output ready);
endinterface

interface arlbl_result_if;
    import arlbl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [LEVEL_W-1:0]   level;
    logic [PATTERN_W-1:0] led_pattern;
    logic [READING_W-1:0] lowest_seen;
    logic [READING_W-1:0] highest_seen;

    modport source (output valid, output level, output led_pattern,
                    output lowest_seen, output highest_seen, input ready);
    modport sink   (input valid, input level, input led_pattern,
                    input lowest_seen, input highest_seen, output ready);
endinterface

`default_nettype wire

// ===== sv/arlbl_front.sv =====
// ---------------------------------------------------------------------------
// Auto-ranging LED bar level front end
// Converts each sample to offset binary and tracks the extremes seen.
// ---------------------------------------------------------------------------
`default_nettype none

`include "autorange_led_bar_level_macros.svh"

module arlbl_front (
    input  logic               clk,
    input  logic               rst_n,
    arlbl_sample_if.sink       sample_ch,
    arlbl_job_if.source        job_ch
);
    import arlbl_pkg::*;

    logic [READING_W-1:0] lowest_reg,  lowest_next;
    logic [READING_W-1:0] highest_reg, highest_next;
    logic                 seen_reg,    seen_next;

    logic [READING_W-1:0] reading;
    logic [READING_W-1:0] range_w;
    logic                 take;

    assign take    = sample_ch.valid && sample_ch.ready;
    assign reading = sample_ch.sample_word[SAMPLE_W-1 -: READING_W] + READING_OFFSET;

    always_comb
    begin
        if (!seen_reg)
        begin
            lowest_next  = reading;
            highest_next = reading;
        end
        else
        begin
            lowest_next  = (reading < lowest_reg)  ? reading : lowest_reg;
            highest_next = (reading > highest_reg) ? reading : highest_reg;
        end
        seen_next = 1'b1;
    end

    assign range_w = highest_next - lowest_next;

    // The job leaves in the same cycle the sample arrives.
    assign job_ch.valid       = sample_ch.valid;
    assign sample_ch.ready    = job_ch.ready;
    assign job_ch.job.diff    = reading - lowest_next;
    assign job_ch.job.span    = (range_w == '0) ? READING_W'(1) : range_w;
    assign job_ch.job.lowest  = lowest_next;
    assign job_ch.job.highest = highest_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg  <= '0;
            highest_reg <= '0;
            seen_reg    <= 1'b0;
        end
        else if (take)
        begin
            lowest_reg  <= lowest_next;
            highest_reg <= highest_next;
            seen_reg    <= seen_next;
        end
    end

    `ARLBL_ASSERT(a_extremes_ordered, clk, rst_n, seen_reg |-> (lowest_reg <= highest_reg), "lowest reading above highest")
    `ARLBL_ASSERT(a_first_sets_both, clk, rst_n, (take && !seen_reg) |=> (lowest_reg == highest_reg), "first reading did not set both extremes")

endmodule

`default_nettype wire

// ===== sv/arlbl_fifo.sv =====
// ---------------------------------------------------------------------------
// Auto-ranging LED bar level job queue
// Short register queue that decouples the front end from the divider.
// ---------------------------------------------------------------------------
`default_nettype none

module arlbl_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    arlbl_job_if.sink     push_ch,
    arlbl_job_if.source   pop_ch
);
    import arlbl_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic          push;
    logic          pop;

    assign push_ch.ready = (count_reg != CW'(DEPTH));
    assign pop_ch.valid  = (count_reg != '0);
    assign pop_ch.job    = entry_reg[rd_ptr_reg];

    assign push = push_ch.valid && push_ch.ready;
    assign pop  = pop_ch.valid && pop_ch.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_ch.job;
        end
    end

endmodule

`default_nettype wire

// ===== sv/arlbl_back.sv =====
// ---------------------------------------------------------------------------
// Auto-ranging LED bar level back end
// Restoring divider, one quotient bit a cycle, with a result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "autorange_led_bar_level_macros.svh"

module arlbl_back #(
    parameter int LED_COUNT = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    arlbl_job_if.sink       job_ch,
    arlbl_result_if.source  result_ch
);
    import arlbl_pkg::*;

    // The quotient never exceeds LED_COUNT, so QW bits hold it.
    localparam int QW = $clog2(LED_COUNT + 1);
    localparam int NW = READING_W + QW;
    localparam int SW = $clog2(QW);

    back_state_t          state_reg, state_next;
    logic [NW-1:0]        rem_reg,   rem_next;
    logic [QW-1:0]        quo_reg,   quo_next;
    logic [SW-1:0]        step_reg,  step_next;
    logic [READING_W-1:0] span_reg;
    logic [READING_W-1:0] lowest_reg;
    logic [READING_W-1:0] highest_reg;

    logic                 out_valid_reg;
    logic [LEVEL_W-1:0]   level_reg;
    logic [PATTERN_W-1:0] pattern_reg;
    logic [READING_W-1:0] lowest_out_reg;
    logic [READING_W-1:0] highest_out_reg;

    logic                 load;
    logic                 out_load;
    logic                 do_step;
    logic [NW-1:0]        trial;
    logic                 fits;
    logic [QW-1:0]        sat;
    logic [15:0]          wide_pattern;

    assign trial = NW'(span_reg) << step_reg;
    assign fits  = (rem_reg >= trial);
    assign sat   = (quo_reg > QW'(LED_COUNT - 1)) ? QW'(LED_COUNT - 1) : quo_reg;
    assign wide_pattern = 16'(1) << sat;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_ch.valid)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!out_valid_reg || result_ch.ready)
                begin
                    state_next = job_ch.valid ? BK_DIV : BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control outputs of the state machine.
    always_comb
    begin
        load     = 1'b0;
        out_load = 1'b0;
        do_step  = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                load = job_ch.valid;
            end
            BK_DIV:
            begin
                do_step = 1'b1;
            end
            BK_DONE:
            begin
                out_load = !out_valid_reg || result_ch.ready;
                load     = out_load && job_ch.valid;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    assign job_ch.ready = load;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        if (load)
        begin
            rem_next  = NW'(job_ch.job.diff) * NW'(LED_COUNT);
            quo_next  = '0;
            step_next = SW'(QW - 1);
        end
        else if (do_step)
        begin
            rem_next  = fits ? rem_reg - trial : rem_reg;
            quo_next  = {quo_reg[QW-2:0], fits};
            step_next = step_reg - SW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        if (load)
        begin
            span_reg    <= job_ch.job.span;
            lowest_reg  <= job_ch.job.lowest;
            highest_reg <= job_ch.job.highest;
        end
        if (out_load)
        begin
            level_reg       <= LEVEL_W'(sat);
            pattern_reg     <= wide_pattern[PATTERN_W-1:0];
            lowest_out_reg  <= lowest_reg;
            highest_out_reg <= highest_reg;
        end
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.level        = level_reg;
    assign result_ch.led_pattern  = pattern_reg;
    assign result_ch.lowest_seen  = lowest_out_reg;
    assign result_ch.highest_seen = highest_out_reg;

    `ARLBL_NEVER(a_no_pop_while_dividing, clk, rst_n, job_ch.ready && (state_reg == BK_DIV), "job taken mid-division")
    `ARLBL_ASSERT(a_pattern_single_bit, clk, rst_n, result_ch.valid |-> $onehot0(result_ch.led_pattern), "LED pattern has more than one bit")
    `ARLBL_ASSERT(a_result_extremes, clk, rst_n, result_ch.valid |-> (result_ch.lowest_seen <= result_ch.highest_seen), "result extremes out of order")

endmodule

`default_nettype wire

// ===== sv/autorange_led_bar_level.sv =====
// ---------------------------------------------------------------------------
// Auto-ranging LED bar level
// Places each accelerometer reading within the range seen so far.
// ---------------------------------------------------------------------------
// Each beat on sample_ch carries one 16-bit sensor response word whose high
// byte is a signed axis reading; it is shifted to offset binary by adding
// 0x80 with wrap. The block tracks the lowest and highest readings seen since
// reset (the first reading sets both) and, for every sample, returns one beat
// on result_ch with the level (reading - lowest) * LED_COUNT divided by the
// range (a zero range counts as one), saturated at LED_COUNT - 1, the one-hot
// LED pattern for that level, and the extremes including this sample. When
// LED_COUNT exceeds 8, level and pattern are truncated to their 3 and 8 bits.
// A sample is classified in the cycle it is accepted and queued in a
// two-entry queue; the back end then runs a restoring divide that produces
// one quotient bit per cycle. The divider takes one sample at a time and
// sets the sustained rate. The front end keeps taking samples while the
// queue has room, and a finished result waits in the output register
// while the next division runs.
// ---------------------------------------------------------------------------
`default_nettype none

module autorange_led_bar_level #(
    parameter int LED_COUNT = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    arlbl_sample_if.sink     sample_ch,
    arlbl_result_if.source   result_ch
);
    import arlbl_pkg::*;

    // Front end to queue, and queue to divider.
    arlbl_job_if front_job ();
    arlbl_job_if back_job ();

    // Readings become offset binary here and update the extremes.
    arlbl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .job_ch    (front_job)
    );

    // Lets the front end accept while a division is still running.
    arlbl_fifo #(
        .DEPTH (2)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_ch (front_job),
        .pop_ch  (back_job)
    );

    // Scaling divide, saturation and the registered result.
    arlbl_back #(
        .LED_COUNT (LED_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_ch    (back_job),
        .result_ch (result_ch)
    );

endmodule

`default_nettype wire
